// ----- rtl/acd_pkg.sv -----
package acd_pkg;

  localparam int MAX_STEPS     = 20;
  localparam int LUM_FRAC_BITS = 16;
  localparam int NUM_CELLS     = MAX_STEPS + 1;

  localparam int RGB_W   = 24;
  localparam int MC_W    = 12;
  localparam int PCT_W   = 7;
  localparam int LUM_W   = LUM_FRAC_BITS + 1;
  localparam int WSUM_W  = LUM_W + 14;
  localparam int DIV_S   = WSUM_W + 14;
  localparam int DIV_M_W = WSUM_W + 1;
  localparam int CMP_W   = LUM_FRAC_BITS + 18;

  localparam logic [MC_W-1:0]    MIN_CONTRAST_RST = MC_W'(450);
  localparam logic [LUM_W-1:0]   LUM_ONE  = LUM_W'(1) << LUM_FRAC_BITS;
  localparam logic [63:0]        DIV_M64  = ((64'd1 << DIV_S) + 64'd9999) / 64'd10000;
  localparam logic [DIV_M_W-1:0] DIV_M    = DIV_M_W'(DIV_M64);
  localparam logic [RGB_W-1:0]   RGB_BLACK = '0;
  localparam logic [RGB_W-1:0]   RGB_WHITE = '1;

  typedef logic [LUM_W-1:0] lin_tab_t [256];

  // Data handed from one step cell to the next.
  typedef struct packed {
    logic              done;
    logic [RGB_W-1:0]  best;
    logic [RGB_W-1:0]  accent;
    logic [RGB_W-1:0]  target;
    logic [LUM_W-1:0]  lum_bg;
  } step_t;

  function automatic logic [63:0] mul_q31(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 31;
  endfunction

  function automatic logic [LUM_W-1:0] lin_entry(int v);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] x;
    lo = 64'd0;
    hi = 64'd1 << 31;
    if (v <= 10) begin
      x = ((64'(v) * 64'd100) << LUM_FRAC_BITS) + 64'd164730;
      return LUM_W'(x / 64'd329460);
    end
    t  = ((64'(1000 * v + 14025) << 31) + 64'd134512) / 64'd269025;
    t2 = mul_q31(t, t);
    for (int n = 0; n < 40; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        p = mid;
        for (int k = 0; k < 4; k++) begin
          p = mul_q31(p, mid);
        end
        if (p <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    x = mul_q31(t2, lo);
    return LUM_W'((x + (64'd1 << (30 - LUM_FRAC_BITS))) >> (31 - LUM_FRAC_BITS));
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = lin_entry(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin();

  // One channel: floor((a*(100-p) + b*p + 50) / 100), divide by reciprocal.
  function automatic logic [7:0] blend_ch(logic [7:0] a, logic [7:0] b, logic [PCT_W-1:0] p);
    logic [14:0] x;
    logic [30:0] prod;
    x = 15'(a) * (15'd100 - 15'(p)) + 15'(b) * 15'(p) + 15'd50;
    prod = 31'(x) * 31'd41944;
    return prod[22 +: 8];
  endfunction

  function automatic logic [RGB_W-1:0] blend_rgb(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b,
                                                  logic [PCT_W-1:0] p);
    return {blend_ch(a[23:16], b[23:16], p),
            blend_ch(a[15:8], b[15:8], p),
            blend_ch(a[7:0], b[7:0], p)};
  endfunction

  function automatic logic [WSUM_W-1:0] lum_wsum(logic [RGB_W-1:0] rgb);
    logic [WSUM_W-1:0] r;
    logic [WSUM_W-1:0] g;
    logic [WSUM_W-1:0] b;
    r = WSUM_W'(LIN_TABLE[rgb[23:16]]);
    g = WSUM_W'(LIN_TABLE[rgb[15:8]]);
    b = WSUM_W'(LIN_TABLE[rgb[7:0]]);
    return WSUM_W'(r * 2126) + WSUM_W'(g * 7152) + WSUM_W'(b * 722) + WSUM_W'(5000);
  endfunction

  function automatic logic [LUM_W-1:0] div10000(logic [WSUM_W-1:0] x);
    logic [WSUM_W+DIV_M_W-1:0] prod;
    prod = (WSUM_W + DIV_M_W)'(x) * (WSUM_W + DIV_M_W)'(DIV_M);
    return prod[DIV_S +: LUM_W];
  endfunction

  function automatic logic clears(logic [LUM_W-1:0] la, logic [LUM_W-1:0] lb,
                                  logic [MC_W-1:0] mc);
    logic [LUM_W-1:0] hi;
    logic [LUM_W-1:0] lo;
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    hi  = (la > lb) ? la : lb;
    lo  = (la > lb) ? lb : la;
    lhs = CMP_W'(100) * (CMP_W'(20) * CMP_W'(hi) + CMP_W'(LUM_ONE));
    rhs = CMP_W'(mc) * (CMP_W'(20) * CMP_W'(lo) + CMP_W'(LUM_ONE));
    return lhs >= rhs;
  endfunction

endpackage

// ----- rtl/acd_if.sv -----
interface acd_in_if;
  logic                        valid;
  logic                        ready;
  logic [acd_pkg::RGB_W-1:0]   surface_rgb;
  logic [acd_pkg::RGB_W-1:0]   bg_rgb;
  logic [acd_pkg::RGB_W-1:0]   line_rgb;
  logic [acd_pkg::RGB_W-1:0]   accent_rgb;

  modport source (output valid, surface_rgb, bg_rgb, line_rgb, accent_rgb, input ready);
  modport sink   (input valid, surface_rgb, bg_rgb, line_rgb, accent_rgb, output ready);
endinterface

interface acd_out_if;
  logic                        valid;
  logic                        ready;
  logic [acd_pkg::RGB_W-1:0]   tint_rgb;
  logic [acd_pkg::RGB_W-1:0]   tint2_rgb;
  logic [acd_pkg::RGB_W-1:0]   soft_rgb;
  logic [acd_pkg::RGB_W-1:0]   deep_rgb;
  logic [acd_pkg::RGB_W-1:0]   rule_mix_rgb;
  logic [acd_pkg::RGB_W-1:0]   text_rgb;

  modport source (output valid, tint_rgb, tint2_rgb, soft_rgb, deep_rgb, rule_mix_rgb,
                  text_rgb, input ready);
  modport sink   (input valid, tint_rgb, tint2_rgb, soft_rgb, deep_rgb, rule_mix_rgb,
                  text_rgb, output ready);
endinterface

// ----- rtl/acd_cell.sv -----
module acd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [acd_pkg::MC_W-1:0]      min_contrast_i,
  input  logic [acd_pkg::PCT_W-1:0]     pct_i,
  input  logic                          valid_i,
  input  acd_pkg::step_t                step_i,
  output logic                          valid_o,
  output acd_pkg::step_t                step_o
);

  logic                          v1_q, v2_q, v3_q, v4_q;
  acd_pkg::step_t                s1_q, s2_q, s3_q, s4_q;
  logic [acd_pkg::RGB_W-1:0]     cand1_q, cand2_q, cand3_q;
  logic [acd_pkg::WSUM_W-1:0]    wsum2_q;
  logic [acd_pkg::LUM_W-1:0]     lum3_q;
  logic                          clr;

  assign clr = acd_pkg::clears(lum3_q, s3_q.lum_bg, min_contrast_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= step_i;
    cand1_q <= acd_pkg::blend_rgb(step_i.accent, step_i.target, pct_i);
    s2_q    <= s1_q;
    cand2_q <= cand1_q;
    wsum2_q <= acd_pkg::lum_wsum(cand1_q);
    s3_q    <= s2_q;
    cand3_q <= cand2_q;
    lum3_q  <= acd_pkg::div10000(wsum2_q);
    // An earlier step that cleared keeps its colour; otherwise this step's
    // candidate becomes the best so far.
    s4_q    <= {s3_q.done | clr, s3_q.done ? s3_q.best : cand3_q,
                s3_q.accent, s3_q.target, s3_q.lum_bg};
  end

  assign valid_o = v4_q;
  assign step_o  = s4_q;

endmodule

// ----- rtl/accent_color_derivation.sv -----
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   surface_rgb, bg_rgb, line_rgb, accent_rgb
// out_o     out  valid/ready   tint_rgb .. rule_mix_rgb, text_rgb
// cfg       in   cfg_we_i      cfg_data_i (min_contrast)
//
// A result is offered after its input transaction has passed the input
// registers, the fixed blends and background weighted sum, the background
// luminance and then each step cell in turn. One item is in flight at a time,
// so the next input transaction is accepted only after the result is taken.
// Reset sets min_contrast to 450 and empties the chain and the output register.
// A stalled result holds in the output register; the input waits until it goes.
module accent_color_derivation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acd_pkg::MC_W-1:0]    cfg_data_i,
  acd_in_if.sink                      in_i,
  acd_out_if.source                   out_o
);

  logic [acd_pkg::MC_W-1:0]    min_contrast_q;
  logic                        busy_q;
  logic                        f0_q, f1_q, f2_q;
  logic                        out_valid_q;
  logic [acd_pkg::RGB_W-1:0]   surface_q, bg_q, line_q, accent_q;
  logic [acd_pkg::RGB_W-1:0]   tint_q, tint2_q, soft_q, deep_q, rule_q, text_q;
  logic [acd_pkg::WSUM_W-1:0]  wsum_bg_q;
  logic [acd_pkg::LUM_W-1:0]   lum_bg_q;
  logic [acd_pkg::RGB_W-1:0]   step0_target;
  logic                        in_acc;
  logic                        out_acc;

  logic                        cell_valid [acd_pkg::NUM_CELLS+1];
  acd_pkg::step_t              cell_step  [acd_pkg::NUM_CELLS+1];
  logic [acd_pkg::NUM_CELLS:0] valid_vec;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign in_i.ready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_contrast_q <= acd_pkg::MIN_CONTRAST_RST;
      busy_q         <= 1'b0;
      f0_q           <= 1'b0;
      f1_q           <= 1'b0;
      f2_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_contrast_q <= cfg_data_i;
      end
      f0_q <= in_acc;
      f1_q <= f0_q;
      f2_q <= f1_q;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (out_acc) begin
        busy_q <= 1'b0;
      end
      if (cell_valid[acd_pkg::NUM_CELLS]) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      surface_q <= in_i.surface_rgb;
      bg_q      <= in_i.bg_rgb;
      line_q    <= in_i.line_rgb;
      accent_q  <= in_i.accent_rgb;
    end
    if (f0_q) begin
      tint_q    <= acd_pkg::blend_rgb(surface_q, accent_q, acd_pkg::PCT_W'(8));
      tint2_q   <= acd_pkg::blend_rgb(surface_q, accent_q, acd_pkg::PCT_W'(16));
      soft_q    <= acd_pkg::blend_rgb(bg_q, accent_q, acd_pkg::PCT_W'(12));
      deep_q    <= acd_pkg::blend_rgb(accent_q, acd_pkg::RGB_BLACK, acd_pkg::PCT_W'(22));
      rule_q    <= acd_pkg::blend_rgb(line_q, accent_q, acd_pkg::PCT_W'(45));
      wsum_bg_q <= acd_pkg::lum_wsum(bg_q);
    end
    if (f1_q) begin
      lum_bg_q <= acd_pkg::div10000(wsum_bg_q);
    end
    if (cell_valid[acd_pkg::NUM_CELLS]) begin
      text_q <= cell_step[acd_pkg::NUM_CELLS].best;
    end
  end

  // The first cell blends by zero percent, which checks the accent itself.
  assign step0_target  = ({1'b0, lum_bg_q} << 1) > {1'b0, acd_pkg::LUM_ONE} ?
                         acd_pkg::RGB_BLACK : acd_pkg::RGB_WHITE;
  assign cell_valid[0] = f2_q;
  assign cell_step[0]  = {1'b0, accent_q, accent_q, step0_target, lum_bg_q};

  for (genvar k = 0; k < acd_pkg::NUM_CELLS; k++) begin : g_cell
    localparam int PCT = (5 * k > 100) ? 100 : 5 * k;
    acd_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .min_contrast_i (min_contrast_q),
      .pct_i          (acd_pkg::PCT_W'(PCT)),
      .valid_i        (cell_valid[k]),
      .step_i         (cell_step[k]),
      .valid_o        (cell_valid[k+1]),
      .step_o         (cell_step[k+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= acd_pkg::NUM_CELLS; k++) begin
      valid_vec[k] = cell_valid[k];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tint_rgb     = tint_q;
  assign out_o.tint2_rgb    = tint2_q;
  assign out_o.soft_rgb     = soft_q;
  assign out_o.deep_rgb     = deep_q;
  assign out_o.rule_mix_rgb = rule_q;
  assign out_o.text_rgb     = text_q;

  a_out_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q) else $error("result shown with no item in flight");

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid_vec)) else $error("more than one item in the step chain");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready) else $error("input still ready after a transaction");

endmodule

// ----- bench/acd_color_checker.sv -----
module acd_color_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [acd_pkg::MC_W-1:0]  cfg_data_i,
  acd_in_if                         in_mon,
  acd_out_if                        out_mon,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        adjusted_o
);

  typedef logic [acd_pkg::RGB_W-1:0] rgb_t;

  typedef struct {
    rgb_t tint;
    rgb_t tint2;
    rgb_t soft_mix;
    rgb_t deep;
    rgb_t rule_mix;
    rgb_t text;
  } palette_t;

  logic [63:0]              lin_q [256];
  logic [acd_pkg::MC_W-1:0] contrast_min;
  palette_t                 palette_q[$];
  int                       fails = 0;
  int                       pending_n = 0;
  int                       checks = 0;
  int                       adjusts = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending_n;
  assign checked_o    = checks;
  assign adjusted_o   = adjusts;

  function automatic logic [63:0] q31_mul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 31;
  endfunction

  // sRGB to linear in Q1.16: power 2.4 done as (t^2) * t^(2/5) by binary search.
  function automatic logic [63:0] srgb_to_linear(int v);
    logic [63:0] t;
    logic [63:0] sq;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] pw;
    if (v <= 10)
      return ((64'(v) * 100 << acd_pkg::LUM_FRAC_BITS) + 164730) / 329460;
    t  = ((64'(1000 * v + 14025) << 31) + 134512) / 269025;
    sq = q31_mul(t, t);
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      pw  = mid;
      repeat (4) pw = q31_mul(pw, mid);
      if (pw <= sq) lo = mid;
      else hi = mid - 1;
    end
    return (q31_mul(sq, lo) + (64'd1 << (30 - acd_pkg::LUM_FRAC_BITS)))
           >> (31 - acd_pkg::LUM_FRAC_BITS);
  endfunction

  function automatic logic [63:0] rel_lum(rgb_t c);
    return (2126 * lin_q[c[23:16]] + 7152 * lin_q[c[15:8]] + 722 * lin_q[c[7:0]]
            + 5000) / 10000;
  endfunction

  function automatic bit contrast_ok(rgb_t a, rgb_t b);
    logic [63:0] la;
    logic [63:0] lb;
    logic [63:0] hi;
    logic [63:0] lo;
    la = rel_lum(a);
    lb = rel_lum(b);
    hi = (la > lb) ? la : lb;
    lo = (la > lb) ? lb : la;
    return 100 * (20 * hi + (64'd1 << acd_pkg::LUM_FRAC_BITS))
           >= 64'(contrast_min) * (20 * lo + (64'd1 << acd_pkg::LUM_FRAC_BITS));
  endfunction

  function automatic rgb_t mix(rgb_t a, rgb_t b, int pct);
    rgb_t r;
    int   p;
    p = (pct > 100) ? 100 : pct;
    for (int sh = 0; sh < 24; sh += 8)
      r[sh +: 8] = 8'((int'(a[sh +: 8]) * (100 - p) + int'(b[sh +: 8]) * p + 50) / 100);
    return r;
  endfunction

  function automatic palette_t derive_palette(rgb_t surface, rgb_t bg, rgb_t line_c,
                                              rgb_t accent);
    palette_t pal;
    rgb_t     toward;
    pal.tint     = mix(surface, accent, 8);
    pal.tint2    = mix(surface, accent, 16);
    pal.soft_mix = mix(bg, accent, 12);
    pal.deep     = mix(accent, acd_pkg::RGB_BLACK, 22);
    pal.rule_mix = mix(line_c, accent, 45);
    pal.text     = accent;
    if (!contrast_ok(accent, bg)) begin
      toward = (2 * rel_lum(bg) > (64'd1 << acd_pkg::LUM_FRAC_BITS)) ?
               acd_pkg::RGB_BLACK : acd_pkg::RGB_WHITE;
      for (int i = 1; i <= acd_pkg::MAX_STEPS; i++) begin
        pal.text = mix(accent, toward, 5 * i);
        if (contrast_ok(pal.text, bg)) break;
      end
    end
    return pal;
  endfunction

  initial begin
    for (int v = 0; v < 256; v++) lin_q[v] = srgb_to_linear(v);
  end

  task automatic compare(string what, rgb_t exp_v, rgb_t act_v);
    if (exp_v !== act_v) begin
      fails++;
      if (fails <= 10)
        $display("%0t mismatch %s: expected %06h actual %06h", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    palette_t pal;
    if (!rst_ni) begin
      contrast_min <= acd_pkg::MIN_CONTRAST_RST;
    end else begin
      if (cfg_we_i) contrast_min <= cfg_data_i;
      if (in_mon.valid && in_mon.ready) begin
        pal = derive_palette(in_mon.surface_rgb, in_mon.bg_rgb, in_mon.line_rgb,
                             in_mon.accent_rgb);
        if (pal.text != in_mon.accent_rgb) adjusts++;
        palette_q.insert(palette_q.size(), pal);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (palette_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t result transaction with nothing expected", $realtime);
        end else begin
          pal = palette_q.pop_front();
          compare("tint_rgb", pal.tint, out_mon.tint_rgb);
          compare("tint2_rgb", pal.tint2, out_mon.tint2_rgb);
          compare("soft_rgb", pal.soft_mix, out_mon.soft_rgb);
          compare("deep_rgb", pal.deep, out_mon.deep_rgb);
          compare("rule_mix_rgb", pal.rule_mix, out_mon.rule_mix_rgb);
          compare("text_rgb", pal.text, out_mon.text_rgb);
          checks++;
        end
      end
      pending_n = palette_q.size();
    end
  end

endmodule

// ----- bench/accent_color_derivation_tb.sv -----
module accent_color_derivation_tb;

  localparam int RANDOM_ITEMS = 1180;
  localparam int DRAIN_CYCLES = 120;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [acd_pkg::MC_W-1:0] cfg_data;
  int                       fail_count;
  int                       pending;
  int                       checked;
  int                       adjusted;
  int                       sent;
  int                       settings_used;
  bit                       quiet;
  bit                       hold_request;

  acd_in_if  in_ch ();
  acd_out_if out_ch ();

  accent_color_derivation DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  acd_color_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .adjusted_o   (adjusted)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d transactions outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 12));
      1:       return 8'($urandom_range(243, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [acd_pkg::RGB_W-1:0] pick_color();
    logic [7:0] g;
    case ($urandom_range(0, 4))
      0: begin
        g = pick_channel();
        return {g, g, g};
      end
      1:       return {pick_channel(), pick_channel(), pick_channel()};
      default: return acd_pkg::RGB_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [acd_pkg::RGB_W-1:0] surface, logic [acd_pkg::RGB_W-1:0] bg,
                           logic [acd_pkg::RGB_W-1:0] line_c,
                           logic [acd_pkg::RGB_W-1:0] accent);
    in_ch.surface_rgb = surface;
    in_ch.bg_rgb      = bg;
    in_ch.line_rgb    = line_c;
    in_ch.accent_rgb  = accent;
    in_ch.valid       = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_min_contrast(logic [acd_pkg::MC_W-1:0] value);
    wait_idle();
    cfg_data = value;
    cfg_we   = 1'b1;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [acd_pkg::MC_W-1:0] phase_setting [6];
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.surface_rgb = '0;
    in_ch.bg_rgb      = '0;
    in_ch.line_rgb    = '0;
    in_ch.accent_rgb  = '0;
    sent          = 0;
    settings_used = 1;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    phase_setting = '{acd_pkg::MC_W'(100), acd_pkg::MC_W'(2100), acd_pkg::MC_W'(0),
                      acd_pkg::MC_W'(4095), acd_pkg::MC_W'(450), acd_pkg::MC_W'(700)};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, accents already readable, pushes toward black and white.
    send_item(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_item(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, 24'h000000, 24'h808080, 24'hFFFFFF);
    send_item(24'h000000, 24'hFFFFFF, 24'h808080, 24'h000000);
    send_item(24'hF0F0F0, 24'hFFFFFF, 24'hD0D0D0, 24'h4A90E2);
    send_item(24'h101010, 24'h000000, 24'h303030, 24'h1E3A8A);
    send_item(24'h0A0A0A, 24'h0B0B0B, 24'h050505, 24'h0A0B09);
    send_item(24'h777777, 24'h777777, 24'h777777, 24'h767676);
    send_item(24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF00FF);
    send_item(24'h0B0C0D, 24'hBCBCBC, 24'hF5F5F5, 24'hB8B8B8);
    send_item(24'hAAAAAA, 24'h555555, 24'h5A5A5A, 24'h5C5C5C);
    send_item(24'h123456, 24'hFEDCBA, 24'h89ABCD, 24'hFFD700);
    send_item(24'hFFFFFF, 24'h767676, 24'h010101, 24'h777777);
    set_min_contrast(acd_pkg::MC_W'(2100));
    send_item(24'h808080, 24'h808080, 24'h808080, 24'h808080);
    send_item(24'h000000, 24'h000000, 24'h000000, 24'h0000FF);
    send_item(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFF00);
    set_min_contrast(acd_pkg::MC_W'(0));
    send_item(24'h808080, 24'h808080, 24'h808080, 24'h808080);

    for (int ph = 0; ph < 6; ph++) begin
      set_min_contrast(ph == 5 ? acd_pkg::MC_W'($urandom_range(100, 2100)) :
                                 phase_setting[ph]);
      if (ph == 1) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        if (ph == 5 && n > 100) quiet = 1'b1;
        if (ph == 3 && n == 80) wait_idle();
        send_item(pick_color(), pick_color(), pick_color(), pick_color());
      end
    end

    wait_idle();
    $display("%0d transactions sent, %0d results checked under %0d contrast settings",
             sent, checked, settings_used);
    $display("%0d text colors were stepped toward black or white", adjusted);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
